FILE: hw/rtl/msf_pkg.sv
// Shared types and constants of the message segmenting framer.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package msf_pkg;

    // Largest number of data bytes in one frame.
    localparam int FRAME_DATA_MAX = 512;

    // Width of a frame length, wide enough to hold FRAME_DATA_MAX itself.
    localparam int LEN_W = $clog2(FRAME_DATA_MAX + 1);

    // Frame limit at message-size width and at frame-length width.
    localparam logic [15:0]      FRAME_MAX_16  = 16'(FRAME_DATA_MAX);
    localparam logic [LEN_W-1:0] FRAME_MAX_LEN = LEN_W'(FRAME_DATA_MAX);

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_DATA_CMD    = 2'd2;

    // Configuration values seen by the back end.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] data_cmd;
    } t_cfg;

    // One command from the front end: the output work caused by one input item.
    // A start command sends a header, then a checksum if the message is empty.
    // A data command sends the byte, then a checksum if the frame ends, then a
    // header if the message continues.
    typedef struct packed {
        logic             is_start;
        logic [7:0]       data;
        logic             do_close;
        logic             do_open;
        logic [LEN_W-1:0] len;
        logic [7:0]       frame_num;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/msf_front.sv
// Front end of the framer: accepts input items, tracks message and frame progress
// and turns each useful item into one command. Depends on msf_pkg.
`default_nettype none

module msf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_operation,
    input  wire logic [15:0]   i_message_size,
    input  wire logic [7:0]    i_payload_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output msf_pkg::t_cmd      o_cmd
);

    logic [15:0]               r_msg_left, n_msg_left;
    logic [msf_pkg::LEN_W-1:0] r_frm_left, n_frm_left;
    logic [7:0]                r_frame_idx, n_frame_idx;

    logic                      accept;
    logic                      start_last;
    logic [15:0]               msg_dec;
    logic                      next_last;
    logic [7:0]                idx_inc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign start_last = (i_message_size <= msf_pkg::FRAME_MAX_16);
    assign msg_dec    = r_msg_left - 16'd1;
    assign next_last  = (msg_dec <= msf_pkg::FRAME_MAX_16);
    assign idx_inc    = r_frame_idx + 8'd1;

    // Classify the item and build its command.
    always_comb begin
        n_msg_left  = r_msg_left;
        n_frm_left  = r_frm_left;
        n_frame_idx = r_frame_idx;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.data  = i_payload_byte;
        if (accept) begin
            if (i_operation == msf_pkg::OP_START) begin
                o_push          = 1'b1;
                o_cmd.is_start  = 1'b1;
                o_cmd.do_close  = (i_message_size == 16'd0);
                o_cmd.len       = start_last ? i_message_size[msf_pkg::LEN_W-1:0]
                                             : msf_pkg::FRAME_MAX_LEN;
                o_cmd.frame_num = start_last ? 8'd0 : 8'd1;
                n_msg_left      = i_message_size;
                n_frm_left      = o_cmd.len;
                n_frame_idx     = 8'd1;
            end else if (r_msg_left != 16'd0 && r_frm_left != '0) begin
                // A payload byte with no frame open is dropped silently.
                o_push         = 1'b1;
                o_cmd.do_close = (r_frm_left == msf_pkg::LEN_W'(1));
                o_cmd.do_open  = o_cmd.do_close && (msg_dec != 16'd0);
                n_msg_left     = msg_dec;
                n_frm_left     = r_frm_left - msf_pkg::LEN_W'(1);
                if (o_cmd.do_open) begin
                    o_cmd.len       = next_last ? msg_dec[msf_pkg::LEN_W-1:0]
                                                : msf_pkg::FRAME_MAX_LEN;
                    o_cmd.frame_num = next_last ? 8'd0 : idx_inc;
                    n_frm_left      = o_cmd.len;
                    n_frame_idx     = idx_inc;
                end
            end
        end
    end

    // Progress registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_left  <= 16'd0;
            r_frm_left  <= '0;
            r_frame_idx <= 8'd0;
        end else begin
            r_msg_left  <= n_msg_left;
            r_frm_left  <= n_frm_left;
            r_frame_idx <= n_frame_idx;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/msf_cmd_queue.sv
// Short first-in first-out queue of commands between the framer's front and back.
// Depends on msf_pkg for the command type and the queue depth.
`default_nettype none

module msf_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  msf_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output msf_pkg::t_cmd      o_cmd
);

    msf_pkg::t_cmd              r_mem [msf_pkg::QUEUE_DEPTH];
    logic [msf_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [msf_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [msf_pkg::QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == msf_pkg::QCNT_W'(msf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + msf_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + msf_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + msf_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - msf_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/msf_back.sv
// Back end of the framer: expands queued commands into the framed byte stream,
// keeping the running checksum and the packet counter. Depends on msf_pkg.
`default_nettype none

module msf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  msf_pkg::t_cfg      i_cfg,
    input  wire logic          i_q_valid,
    input  msf_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_line_byte,
    output logic               o_frame_done,
    output logic               o_run_last
);

    // Byte positions within the work of one command.
    localparam logic [3:0] ST_SYNC1 = 4'd0;
    localparam logic [3:0] ST_SYNC2 = 4'd1;
    localparam logic [3:0] ST_LENH  = 4'd2;
    localparam logic [3:0] ST_LENL  = 4'd3;
    localparam logic [3:0] ST_CMD   = 4'd4;
    localparam logic [3:0] ST_PKT   = 4'd5;
    localparam logic [3:0] ST_FNUM  = 4'd6;
    localparam logic [3:0] ST_DATA  = 4'd7;
    localparam logic [3:0] ST_CSUM  = 4'd8;

    msf_pkg::t_cmd r_cmd, n_cmd;
    logic [3:0]    r_step, n_step;
    logic          r_active, n_active;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_pkt, n_pkt;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_done, n_out_done;
    logic          r_out_last, n_out_last;

    logic          out_free;
    logic          emit;
    logic [7:0]    cur_byte;
    logic          step_last;
    logic [3:0]    step_next;
    logic [15:0]   len16;

    assign len16    = 16'(r_cmd.len);
    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_active && out_free;
    assign o_pop    = i_q_valid && (!r_active || (emit && step_last));

    // Byte of the current position and the position that follows it.
    always_comb begin
        cur_byte  = 8'd0;
        step_next = r_step + 4'd1;
        step_last = 1'b0;
        unique case (r_step)
            ST_SYNC1: cur_byte = i_cfg.sync_first;
            ST_SYNC2: cur_byte = i_cfg.sync_second;
            ST_LENH:  cur_byte = len16[15:8];
            ST_LENL:  cur_byte = len16[7:0];
            ST_CMD:   cur_byte = i_cfg.data_cmd;
            ST_PKT:   cur_byte = r_pkt;
            ST_FNUM: begin
                cur_byte  = r_cmd.frame_num;
                step_next = ST_CSUM;
                step_last = !(r_cmd.is_start && r_cmd.do_close);
            end
            ST_DATA: begin
                cur_byte  = r_cmd.data;
                step_next = ST_CSUM;
                step_last = !r_cmd.do_close;
            end
            ST_CSUM: begin
                cur_byte  = r_sum;
                step_next = ST_SYNC1;
                step_last = r_cmd.is_start || !r_cmd.do_open;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    // Sequencer, checksum, packet counter and output register.
    always_comb begin
        n_cmd       = r_cmd;
        n_step      = r_step;
        n_active    = r_active;
        n_sum       = r_sum;
        n_pkt       = r_pkt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_done  = r_out_done;
        n_out_last  = r_out_last;

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_done  = (r_step == ST_CSUM);
            n_out_last  = step_last;
            if (r_step == ST_SYNC1) begin
                n_sum = cur_byte;
            end else if (r_step != ST_CSUM) begin
                n_sum = r_sum + cur_byte;
            end
            if (r_step == ST_CSUM) begin
                n_pkt = (r_pkt == 8'hff) ? 8'd1 : r_pkt + 8'd1;
            end
            if (step_last) begin
                n_active = 1'b0;
            end else begin
                n_step = step_next;
            end
        end

        // A new command is taken once the previous one has sent its last byte.
        if (o_pop) begin
            n_cmd    = i_q_cmd;
            n_step   = i_q_cmd.is_start ? ST_SYNC1 : ST_DATA;
            n_active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_step     <= n_step;
        r_out_byte <= n_out_byte;
        r_out_done <= n_out_done;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_sum       <= 8'd0;
            r_pkt       <= 8'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_sum       <= n_sum;
            r_pkt       <= n_pkt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_line_byte  = r_out_byte;
    assign o_frame_done = r_out_done;
    assign o_run_last   = r_out_last;

endmodule

`default_nettype wire

FILE: hw/rtl/message_segmenting_framer_unit.sv
// Top level of the message segmenting framer: configuration registers, front end,
// command queue and back end. Depends on msf_pkg, msf_front, msf_cmd_queue, msf_back.
`default_nettype none

// A start item announces a message; the payload bytes that follow are cut into
// frames of up to 512 data bytes, each sent as two sync bytes, a 16-bit length,
// the command byte, the packet counter, the frame number (0 on the last frame),
// the data and an 8-bit additive checksum. The output gives one byte per cycle
// while the sink takes it. An input item is taken in the cycle it arrives as long
// as the four-entry command queue has room; a payload byte costs one output byte,
// and a frame boundary costs eight more (checksum plus next header), during which
// up to four further items are absorbed by the queue before the input stalls.
// Commands pass the queue into r_cmd; their bytes leave via r_out_byte. Configuration
// writes take effect at once and should be made only while the block is idle.
module message_segmenting_framer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_message_size,
    input  wire logic [7:0]  i_payload_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_line_byte,
    output logic             o_frame_done,
    output logic             o_run_last
);

    msf_pkg::t_cfg r_cfg;
    msf_pkg::t_cmd push_cmd;
    msf_pkg::t_cmd q_cmd;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                msf_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_wdata;
                msf_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_wdata;
                msf_pkg::CFG_DATA_CMD:    r_cfg.data_cmd    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    msf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_message_size (i_message_size),
        .i_payload_byte (i_payload_byte),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    msf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    msf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_line_byte  (o_line_byte),
        .o_frame_done (o_frame_done),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire

FILE: verif/message_segmenting_framer_unit_tb.sv
// Self-checking testbench for the message segmenting framer unit.
// Depends on msf_pkg and message_segmenting_framer_unit; it predicts every framed byte
// and compares it with each output transfer.
`timescale 1ns / 100ps
`default_nettype none

module message_segmenting_framer_unit_tb;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 40;

    // One input item and one framed output byte.
    typedef struct packed {
        logic        op;
        logic [15:0] size;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_done;
        logic       run_last;
    } t_line;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_addr     = msf_pkg::CFG_SYNC_FIRST;
    logic [7:0]  i_cfg_wdata    = 8'h00;
    logic        i_valid        = 1'b0;
    logic        i_operation    = msf_pkg::OP_START;
    logic [15:0] i_message_size = 16'h0000;
    logic [7:0]  i_payload_byte = 8'h00;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_line_byte;
    logic        o_frame_done;
    logic        o_run_last;

    message_segmenting_framer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_message_size (i_message_size),
        .i_payload_byte (i_payload_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_line_byte    (o_line_byte),
        .o_frame_done   (o_frame_done),
        .o_run_last     (o_run_last)
    );

    always #6 i_clk = ~i_clk;

    // Stimulus and expectations shared between the processes.
    t_item       items_to_send[$];
    t_line       line_bytes_due[$];
    int          items_unaccepted = 0;
    int unsigned sender_idle_pct  = 0;
    int unsigned sink_stall_pct   = 0;
    int unsigned error_count      = 0;
    int unsigned cycle_count      = 0;

    // Shadow of the framer: configuration and message progress.
    msf_pkg::t_cfg             cfg_shadow    = '0;
    logic [7:0]                packet_count  = 8'd1;
    logic [15:0]               message_left  = 16'd0;
    logic [msf_pkg::LEN_W-1:0] frame_left    = '0;
    logic [7:0]                frame_ordinal = 8'd0;
    logic [7:0]                frame_sum     = 8'd0;

    function automatic void queue_line_byte(logic [7:0] value, logic done);
        t_line entry;
        entry.line_byte  = value;
        entry.frame_done = done;
        entry.run_last   = 1'b0;
        line_bytes_due.push_back(entry);
    endfunction

    function automatic void queue_summed_byte(logic [7:0] value);
        frame_sum = frame_sum + value;
        queue_line_byte(value, 1'b0);
    endfunction

    // Header of a new frame for whatever remains of the message.
    function automatic void open_frame();
        logic [15:0] frame_len;
        logic        is_final;
        is_final  = (message_left <= msf_pkg::FRAME_MAX_16);
        frame_len = is_final ? message_left : msf_pkg::FRAME_MAX_16;
        frame_left = frame_len[msf_pkg::LEN_W-1:0];
        frame_sum  = 8'd0;
        queue_summed_byte(cfg_shadow.sync_first);
        queue_summed_byte(cfg_shadow.sync_second);
        queue_summed_byte(frame_len[15:8]);
        queue_summed_byte(frame_len[7:0]);
        queue_summed_byte(cfg_shadow.data_cmd);
        queue_summed_byte(packet_count);
        queue_summed_byte(is_final ? 8'd0 : frame_ordinal);
    endfunction

    // Checksum byte, then the packet counter moves on and skips zero.
    function automatic void close_frame();
        queue_line_byte(frame_sum, 1'b1);
        packet_count = (packet_count < 8'd255) ? packet_count + 8'd1 : 8'd1;
    endfunction

    // Works out the framed bytes that one accepted item causes.
    function automatic void frame_input(t_item item);
        int    due_before;
        t_line tail;
        due_before = line_bytes_due.size();
        if (item.op == msf_pkg::OP_START) begin
            message_left  = item.size;
            frame_ordinal = 8'd1;
            open_frame();
            if (message_left == 16'd0)
                close_frame();
        end else if (message_left != 16'd0 && frame_left != '0) begin
            queue_summed_byte(item.data);
            frame_left   = frame_left - 1'b1;
            message_left = message_left - 16'd1;
            if (frame_left == '0) begin
                close_frame();
                if (message_left != 16'd0) begin
                    frame_ordinal = frame_ordinal + 8'd1;
                    open_frame();
                end
            end
        end
        if (line_bytes_due.size() > due_before) begin
            tail = line_bytes_due.pop_back();
            tail.run_last = 1'b1;
            line_bytes_due.push_back(tail);
        end
    endfunction

    // Input side: offers queued items and predicts each one on its transfer.
    always @(posedge i_clk) begin : drive_items
        t_item taken;
        t_item next_item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                taken.op   = i_operation;
                taken.size = i_message_size;
                taken.data = i_payload_byte;
                frame_input(taken);
                items_unaccepted--;
            end
            if (!i_valid || o_ready) begin
                if (items_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_item = items_to_send.pop_front();
                    i_valid        <= 1'b1;
                    i_operation    <= next_item.op;
                    i_message_size <= next_item.size;
                    i_payload_byte <= next_item.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, and every output transfer checked in order.
    always @(posedge i_clk) begin : check_lines
        t_line due;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (line_bytes_due.size() == 0) begin
                    $error("line_byte: no byte expected, got %02h", o_line_byte);
                    error_count++;
                end else begin
                    due = line_bytes_due.pop_front();
                    if (o_line_byte !== due.line_byte) begin
                        $error("line_byte: expected %02h, got %02h", due.line_byte, o_line_byte);
                        error_count++;
                    end
                    if (o_frame_done !== due.frame_done) begin
                        $error("frame_done: expected %0b, got %0b", due.frame_done, o_frame_done);
                        error_count++;
                    end
                    if (o_run_last !== due.run_last) begin
                        $error("run_last: expected %0b, got %0b", due.run_last, o_run_last);
                        error_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_item(logic op, logic [15:0] size, logic [7:0] data);
        t_item item;
        item.op   = op;
        item.size = size;
        item.data = data;
        items_to_send.push_back(item);
        items_unaccepted++;
    endtask

    // A start item followed by a number of payload bytes; unused fields are random.
    task automatic add_message(int unsigned size, int unsigned sent);
        add_item(msf_pkg::OP_START, size[15:0], 8'($urandom_range(0, 255)));
        for (int unsigned k = 0; k < sent; k++)
            add_item(msf_pkg::OP_PAYLOAD, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
    endtask

    // Mostly complete messages, some cut short by the next start, some stray bytes.
    task automatic add_random_traffic(int unsigned target);
        int unsigned counted;
        int unsigned roll;
        int unsigned size;
        int unsigned sent;
        counted = 0;
        while (counted < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
                add_message(size, size);
                counted += size + 1;
            end else if (roll < 85) begin
                size = $urandom_range(0, 65535);
                sent = $urandom_range(0, 6);
                if (sent > size)
                    sent = size;
                add_message(size, sent);
                counted += sent + 1;
            end else begin
                // Stray bytes only count if a cut-short message is still open.
                sent = $urandom_range(1, 3);
                for (int unsigned k = 0; k < sent; k++)
                    add_item(msf_pkg::OP_PAYLOAD, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)));
            end
        end
        size = $urandom_range(0, 6);
        add_message(size, size);
    endtask

    // Writes all three registers while the block is idle.
    task automatic write_config(logic [7:0] sync_first, logic [7:0] sync_second,
                                logic [7:0] data_cmd);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= msf_pkg::CFG_SYNC_FIRST;
        i_cfg_wdata <= sync_first;
        cfg_shadow.sync_first = sync_first;
        @(posedge i_clk);
        i_cfg_addr  <= msf_pkg::CFG_SYNC_SECOND;
        i_cfg_wdata <= sync_second;
        cfg_shadow.sync_second = sync_second;
        @(posedge i_clk);
        i_cfg_addr  <= msf_pkg::CFG_DATA_CMD;
        i_cfg_wdata <= data_cmd;
        cfg_shadow.data_cmd = data_cmd;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every item has been taken and every byte has arrived, then settles.
    task automatic wait_until_idle();
        while (items_unaccepted != 0 || line_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the sync and command bytes at their top value.
        write_config(8'hFF, 8'hFF, 8'hFF);
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        add_item(msf_pkg::OP_START, 16'h0000, 8'h00);          // empty message
        add_item(msf_pkg::OP_PAYLOAD, 16'hFFFF, 8'hFF);        // stray byte while idle
        add_item(msf_pkg::OP_START, 16'h0003, 8'hFF);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h00);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'hFF);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'hA5);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h3C);        // stray byte after the message
        add_item(msf_pkg::OP_START, 16'hFFFF, 8'h00);          // largest size, full-length header
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h5A);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'hC3);
        add_item(msf_pkg::OP_START, 16'h0001, 8'h00);          // start in the middle of a message
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'hFF);
        add_item(msf_pkg::OP_START, 16'hAAAA, 8'h55);
        add_item(msf_pkg::OP_START, 16'h5555, 8'hAA);
        add_item(msf_pkg::OP_START, 16'h0200, 8'h00);          // exactly one full frame announced
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h81);
        add_item(msf_pkg::OP_START, 16'h0002, 8'h00);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h7E);
        add_item(msf_pkg::OP_START, 16'h0000, 8'h00);          // empty message cuts one short
        add_item(msf_pkg::OP_START, 16'h0001, 8'h00);
        add_item(msf_pkg::OP_PAYLOAD, 16'h0000, 8'h01);
        wait_until_idle();

        // No idling: enough empty frames to wrap the packet counter.
        write_config(8'h00, 8'h00, 8'h00);
        add_random_traffic(8);
        for (int k = 0; k < 250; k++)
            add_message(0, 0);
        wait_until_idle();

        // Sender idle most of the time.
        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        sender_idle_pct = 68;
        sink_stall_pct  = 0;
        add_random_traffic(8);
        wait_until_idle();

        // Sink stalling most of the time.
        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        sender_idle_pct = 0;
        sink_stall_pct  = 68;
        add_random_traffic(8);
        wait_until_idle();

        // Both sides idling now and then.
        write_config(8'hFF, 8'h00, 8'($urandom_range(0, 255)));
        sender_idle_pct = 11;
        sink_stall_pct  = 11;
        add_random_traffic(8);
        wait_until_idle();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
